/* design/pnf_pkg.sv */
// Package for the pink noise filter: widths, coefficient table, microcode
// format and the microprogram itself, plus saturation helpers.
// Depends on nothing; every other design file imports it.
package pnf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_WIDTH  = 32;
  localparam int NSEC         = 7;
  localparam int SEC_W        = $clog2(NSEC);
  localparam int COEF_W       = 18;
  localparam int SUM_W        = 32;
  localparam int FRAC_ST      = 23;
  localparam int FRAC_CO      = 17;

  localparam int MAX_W = (STATE_WIDTH > SUM_W) ? STATE_WIDTH : SUM_W;
  localparam int MB_W  = MAX_W;            // multiplier data operand
  localparam int PW    = COEF_W + MB_W;    // product width
  localparam int AW    = MAX_W + 4;        // accumulator, eight terms plus margin

  localparam int POLE_SHIFT = FRAC_CO;
  localparam int FEED_SHIFT = SAMPLE_WIDTH - 7;
  localparam int OUT_SHIFT  = FRAC_ST + FRAC_CO - (SAMPLE_WIDTH - 1);

  localparam int NCOEF  = 15;
  localparam int CIDX_W = $clog2(NCOEF);

  localparam int C_POLE   = 0;
  localparam int C_FEED   = 6;
  localparam int C_DIRECT = 12;
  localparam int C_DELAY  = 13;
  localparam int C_SCALE  = 14;

  localparam int DELAY_SEC = NSEC - 1;

  localparam int NSTEPS  = 17;
  localparam int PC_W    = $clog2(NSTEPS);
  localparam int S_WHITE = 16;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    OS_STATE,
    OS_SAMPLE,
    OS_SUM
  } osel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_POLE,
    OP_SEC,
    OP_DIRECT,
    OP_DELAY,
    OP_OUT,
    OP_WHITE
  } op_t;

  typedef enum logic {
    CD_NONE,
    CD_WHITE
  } cond_t;

  typedef struct packed {
    logic [CIDX_W-1:0] cidx;
    osel_t             osel;
    logic [SEC_W-1:0]  sidx;
    logic [SEC_W-1:0]  widx;
    op_t               op;
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    ucode_t uc;
  } dp_ctrl_t;

  function automatic coef_t coef_rom(input logic [CIDX_W-1:0] idx);
    coef_t c;
    case (idx)
      4'd0:    c = 18'sd130923;
      4'd1:    c = 18'sd130196;
      4'd2:    c = 18'sd127009;
      4'd3:    c = 18'sd113574;
      4'd4:    c = 18'sd72090;
      4'd5:    c = -18'sd99824;
      4'd6:    c = 18'sd7277;
      4'd7:    c = 18'sd9840;
      4'd8:    c = 18'sd20166;
      4'd9:    c = 18'sd40696;
      4'd10:   c = 18'sd69855;
      4'd11:   c = -18'sd2215;
      4'd12:   c = 18'sd70281;
      4'd13:   c = 18'sd15195;
      4'd14:   c = 18'sd14418;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic ucode_t mk(input int c, input osel_t os, input int s, input int w,
                                input op_t op, input cond_t cd, input int t, input logic l);
    ucode_t u;
    u.cidx   = CIDX_W'(c);
    u.osel   = os;
    u.sidx   = SEC_W'(s);
    u.widx   = SEC_W'(w);
    u.op     = op;
    u.cond   = cd;
    u.target = PC_W'(t);
    u.last   = l;
    return u;
  endfunction

  // Each step issues one multiply and retires the product of the step before.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      5'd0:    u = mk(C_POLE + 0, OS_STATE,  0, 0, OP_INIT,   CD_WHITE, S_WHITE, 1'b0);
      5'd1:    u = mk(C_FEED + 0, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd2:    u = mk(C_POLE + 1, OS_STATE,  1, 0, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd3:    u = mk(C_FEED + 1, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd4:    u = mk(C_POLE + 2, OS_STATE,  2, 1, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd5:    u = mk(C_FEED + 2, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd6:    u = mk(C_POLE + 3, OS_STATE,  3, 2, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd7:    u = mk(C_FEED + 3, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd8:    u = mk(C_POLE + 4, OS_STATE,  4, 3, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd9:    u = mk(C_FEED + 4, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd10:   u = mk(C_POLE + 5, OS_STATE,  5, 4, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd11:   u = mk(C_FEED + 5, OS_SAMPLE, 0, 0, OP_POLE,   CD_NONE,  0, 1'b0);
      5'd12:   u = mk(C_DIRECT,   OS_SAMPLE, 0, 5, OP_SEC,    CD_NONE,  0, 1'b0);
      5'd13:   u = mk(C_DELAY,    OS_SAMPLE, 0, 0, OP_DIRECT, CD_NONE,  0, 1'b0);
      5'd14:   u = mk(C_SCALE,    OS_SUM,    0, 0, OP_DELAY,  CD_NONE,  0, 1'b0);
      5'd15:   u = mk(C_SCALE,    OS_SUM,    0, 0, OP_OUT,    CD_NONE,  0, 1'b1);
      5'd16:   u = mk(C_SCALE,    OS_SAMPLE, 0, 0, OP_WHITE,  CD_NONE,  0, 1'b1);
      default: u = mk(C_SCALE,    OS_SAMPLE, 0, 0, OP_NONE,   CD_NONE,  0, 1'b1);
    endcase
    return u;
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [PW:0] x);
    logic signed [STATE_WIDTH-1:0] r;
    if (x[PW:STATE_WIDTH-1] == {(PW-STATE_WIDTH+2){x[PW]}}) begin
      r = x[STATE_WIDTH-1:0];
    end else begin
      r = {x[PW], {(STATE_WIDTH-1){~x[PW]}}};
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [AW-1:0] x);
    logic signed [SUM_W-1:0] r;
    if (x[AW-1:SUM_W-1] == {(AW-SUM_W+1){x[AW-1]}}) begin
      r = x[SUM_W-1:0];
    end else begin
      r = {x[AW-1], {(SUM_W-1){~x[AW-1]}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [PW-1:0] x);
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (x[PW-1:SAMPLE_WIDTH-1] == {(PW-SAMPLE_WIDTH+1){x[PW-1]}}) begin
      r = x[SAMPLE_WIDTH-1:0];
    end else begin
      r = {x[PW-1], {(SAMPLE_WIDTH-1){~x[PW-1]}}};
    end
    return r;
  endfunction

endpackage

/* design/pnf_if.sv */
// Valid/ready stream interfaces for the pink noise filter's sample channels.
// Depends on pnf_pkg for the sample width.
interface pnf_in_if import pnf_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] white_sample;

  modport source (output valid, output white_sample, input ready);
  modport sink   (input valid, input white_sample, output ready);
endinterface

interface pnf_out_if import pnf_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] noise_sample;

  modport source (output valid, output noise_sample, input ready);
  modport sink   (input valid, input noise_sample, output ready);
endinterface

/* design/pnf_seq.sv */
// Microcode sequencer: step counter, program ROM lookup, mode register and
// request handshakes on both channels. Depends on pnf_pkg.
module pnf_seq import pnf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output dp_ctrl_t ctrl
);

  logic            run_r, run_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            mode_r;
  ucode_t          uc;
  logic            accept;
  logic            stall;
  logic            exec;

  assign uc       = ucode_rom(pc_r);
  assign in_ready = !run_r;
  assign accept   = in_valid && in_ready;
  // The final step writes the output register, so it waits while a result is still held.
  assign stall    = uc.last && out_valid_r && !out_ready;
  assign exec     = run_r && !stall;

  assign out_valid = out_valid_r;
  assign ctrl.load = accept;
  assign ctrl.exec = exec;
  assign ctrl.uc   = uc;

  always_comb begin
    run_nxt = run_r;
    pc_nxt  = pc_r;
    if (accept) begin
      run_nxt = 1'b1;
      pc_nxt  = '0;
    end else if (exec) begin
      if (uc.last) begin
        run_nxt = 1'b0;
      end else if (uc.cond == CD_WHITE && !mode_r) begin
        pc_nxt = uc.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec && uc.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> run_r && pc_r == '0)
    else $error("sequencer did not start at step zero");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> pc_r <= PC_W'(NSTEPS - 1))
    else $error("step counter ran past the program");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    exec && uc.last |=> out_valid_r && !run_r)
    else $error("final step did not present a result");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(run_r))
    else $error("result appeared without a request in progress");

endmodule

/* design/pnf_dp.sv */
// Datapath of the pink noise filter: shared multiplier with product register,
// section state registers, accumulator and output register. Depends on pnf_pkg.
module pnf_dp import pnf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dp_ctrl_t                       ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  localparam logic signed [PW-1:0] HALF_POLE = PW'(1) <<< (POLE_SHIFT - 1);
  localparam logic signed [PW-1:0] HALF_FEED = PW'(1) <<< (FEED_SHIFT - 1);
  localparam logic signed [PW-1:0] HALF_OUT  = PW'(1) <<< (OUT_SHIFT - 1);

  logic signed [SAMPLE_WIDTH-1:0] w_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [PW-1:0]           ptmp_r;
  logic signed [AW-1:0]           acc_r;
  logic signed [STATE_WIDTH-1:0]  state_r [NSEC];
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  coef_t                          coef;
  logic signed [MB_W-1:0]         mul_b;
  logic signed [PW-1:0]           prod_nxt;
  logic signed [PW-1:0]           pole_rs;
  logic signed [PW-1:0]           feed_rs;
  logic signed [PW-1:0]           out_rs;
  logic signed [PW:0]             sec_sum;
  logic signed [STATE_WIDTH-1:0]  new_sec;

  always_comb begin
    case (ctrl.uc.osel)
      OS_STATE:  mul_b = MB_W'(state_r[ctrl.uc.sidx]);
      OS_SAMPLE: mul_b = MB_W'(w_r);
      OS_SUM:    mul_b = MB_W'(sat_sum(acc_r));
      default:   mul_b = '0;
    endcase
  end

  assign coef     = coef_rom(ctrl.uc.cidx);
  assign prod_nxt = PW'(coef) * PW'(mul_b);

  // Round half up, then arithmetic shift down to the target format.
  assign pole_rs = (prod_r + HALF_POLE) >>> POLE_SHIFT;
  assign feed_rs = (prod_r + HALF_FEED) >>> FEED_SHIFT;
  assign out_rs  = (prod_r + HALF_OUT) >>> OUT_SHIFT;

  assign sec_sum = (PW+1)'(ptmp_r) + (PW+1)'(feed_rs);
  assign new_sec = sat_state(sec_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSEC; i++) begin
        state_r[i] <= '0;
      end
    end else if (ctrl.exec) begin
      case (ctrl.uc.op)
        OP_SEC:   state_r[ctrl.uc.widx] <= new_sec;
        OP_DELAY: state_r[DELAY_SEC] <= sat_state((PW+1)'(feed_rs));
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w_r <= in_sample;
    end
    if (ctrl.exec) begin
      prod_r <= prod_nxt;
      case (ctrl.uc.op)
        OP_INIT:   acc_r  <= AW'(state_r[DELAY_SEC]);
        OP_POLE:   ptmp_r <= pole_rs;
        OP_SEC:    acc_r  <= acc_r + AW'(new_sec);
        OP_DIRECT: acc_r  <= acc_r + AW'(feed_rs);
        OP_OUT:    out_r  <= sat_sample(out_rs);
        OP_WHITE:  out_r  <= w_r;
        default:   ;
      endcase
    end
  end

  assign out_sample = out_r;

endmodule

/* design/pink_noise_filter.sv */
// Pink noise filter top level: connects the sequencer and datapath to the
// stream channels and the mode register port. Depends on pnf_pkg, pnf_if,
// pnf_seq and pnf_dp.
//
// Usage: white samples (signed Q1.15) arrive on in_ch, one result per request
// leaves on out_ch as a signed Q1.15 sample; copy it to both stereo channels.
// cfg_we with cfg_wdata selects the mode: 0 passes the sample through, 1 runs
// the six pole sections, the direct and delayed terms and the output scaling.
// A 17 step microprogram drives one shared 18 by 32 multiplier; each step
// issues one product and retires the one before.
// In pink mode the steps run in order up to the output step; in white mode the
// first step jumps straight to the pass-through step. The final step of either
// mode writes the output register and raises out_ch.valid.
// in_ch.ready is low while a request is in progress; a finished result waits
// in the output register, and a new request is taken meanwhile.
// If the receiver stalls, the next request runs up to its final step and holds
// there until the waiting result is taken.
// Reset clears the section states, the mode (white), the run state and the output valid flag.
module pink_noise_filter import pnf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  pnf_in_if.sink          in_ch,
  pnf_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  dp_ctrl_t ctrl;

  pnf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl)
  );

  pnf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_sample  (in_ch.white_sample),
    .out_sample (out_ch.noise_sample)
  );

endmodule
